// ----- hw/rtl/mbp_pkg.sv -----
// Package: job type and constants shared by the bit packer modules.
`timescale 1ns / 1ps
`default_nettype none
package mbp_pkg;

  // Command codes on the input channel
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Fixed field widths
  localparam int VALUE_W   = 32;
  localparam int LENGTH_W  = 6;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 7;
  localparam int PCOUNT_W  = 3;
  localparam int ACC_W     = VALUE_W + PEND_W;
  localparam int NBYTES    = VALUE_W / BYTE_W;
  localparam int SEL_W     = $clog2(NBYTES);

  // Job queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // One job: completed bytes right-aligned, oldest byte highest, and the
  // index of the final byte (number of bytes minus one)
  typedef struct packed {
    logic [VALUE_W-1:0] word;
    logic [SEL_W-1:0]   last_sel;
  } mbp_job_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mbp_front.sv -----
// Front end: accepts transactions, tracks the residual bits, builds byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module mbp_front #(
  parameter int MaxFieldBits = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [mbp_pkg::VALUE_W-1:0]   in_field_value,
  input  wire logic [mbp_pkg::LENGTH_W-1:0]  in_field_length,
  input  wire logic                          q_full,
  output logic                               push,
  output mbp_pkg::mbp_job_t                  push_job
);

  logic [mbp_pkg::PEND_W-1:0]   pend_r, pend_nxt;
  logic [mbp_pkg::PCOUNT_W-1:0] pcnt_r, pcnt_nxt;

  logic                         accept;
  logic                         len_ok;
  logic [mbp_pkg::VALUE_W:0]    mask;
  logic [mbp_pkg::VALUE_W-1:0]  masked;
  logic [mbp_pkg::ACC_W-1:0]    acc;
  logic [mbp_pkg::LENGTH_W-1:0] total;
  logic [mbp_pkg::PCOUNT_W-1:0] rem;
  logic [mbp_pkg::PCOUNT_W-1:0] nbytes;
  logic [mbp_pkg::ACC_W-1:0]    emitted;
  logic [mbp_pkg::PEND_W-1:0]   rem_mask;
  logic [mbp_pkg::BYTE_W-1:0]   flush_byte;

  // Stall while the job queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Length must be 1..MaxFieldBits
  assign len_ok = (in_field_length != '0) &&
                  ({1'b0, in_field_length} <= 7'(MaxFieldBits));

  // Append the masked field after the residual bits
  assign mask     = ({{mbp_pkg::VALUE_W{1'b0}}, 1'b1} << in_field_length) - 1'b1;
  assign masked   = in_field_value & mask[mbp_pkg::VALUE_W-1:0];
  assign acc      = ({{mbp_pkg::VALUE_W{1'b0}}, pend_r} << in_field_length) |
                    {{mbp_pkg::PEND_W{1'b0}}, masked};
  assign total    = {3'b000, pcnt_r} + in_field_length;
  assign rem      = total[2:0];
  assign nbytes   = total[5:3];
  assign emitted  = acc >> rem;
  assign rem_mask = ~(7'h7f << rem);

  // Pad the residual with zeros on the right
  assign flush_byte = 8'({pend_r, 1'b0} << (3'd7 - pcnt_r));

  // Build the job and the next residual
  always_comb begin
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    push     = 1'b0;
    push_job = '0;
    if (accept) begin
      if (in_cmd == mbp_pkg::CMD_FINISH) begin
        pend_nxt = '0;
        pcnt_nxt = '0;
        push     = (pcnt_r != '0);
        push_job.word     = {24'h000000, flush_byte};
        push_job.last_sel = '0;
      end else if (len_ok) begin
        pend_nxt = acc[mbp_pkg::PEND_W-1:0] & rem_mask;
        pcnt_nxt = rem;
        push     = (nbytes != '0);
        push_job.word     = emitted[mbp_pkg::VALUE_W-1:0];
        push_job.last_sel = mbp_pkg::SEL_W'(nbytes - 3'd1);
      end
    end
  end

  // Hold the residual between transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mbp_queue.sv -----
// Short job queue between the front end and the byte emitter.
`timescale 1ns / 1ps
`default_nettype none
module mbp_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire mbp_pkg::mbp_job_t push_job,
  output logic             full,
  output logic             head_valid,
  output mbp_pkg::mbp_job_t head_job,
  input  wire logic        pop
);

  localparam int Depth = mbp_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  mbp_pkg::mbp_job_t slots_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == CntW'(Depth));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mbp_back.sv -----
// Back end: emits each queued job's bytes into an output register, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module mbp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        head_valid,
  input  wire mbp_pkg::mbp_job_t           head_job,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mbp_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_last
);

  logic [mbp_pkg::SEL_W-1:0]  sel_r, sel_nxt;
  logic                       valid_r, valid_nxt;
  logic [mbp_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                       last_r, last_nxt;
  logic                       slot_free;
  logic                       is_last;
  logic [mbp_pkg::SEL_W-1:0]  pos;

  assign slot_free = !valid_r || !out_stall;
  assign is_last   = (sel_r == head_job.last_sel);
  assign pos       = head_job.last_sel - sel_r;

  // Load the next byte when the output register frees up
  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (slot_free) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        byte_nxt = head_job.word[pos*mbp_pkg::BYTE_W +: mbp_pkg::BYTE_W];
        last_nxt = is_last;
        if (is_last) begin
          pop     = 1'b1;
          sel_nxt = '0;
        end else begin
          sel_nxt = sel_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/msb_first_bit_packer.sv -----
// Top level: MSB-first bit packer, front end, job queue and byte emitter.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_cmd, in_field_value, in_field_length
//   out_     output     out_valid/out_stall out_byte, out_last
//
// The front end takes one transaction per cycle while the two-entry job queue
// has room; the byte emitter drains one byte per cycle while out_stall is low,
// and a write that completes bytes hands it a single job (up to 4 bytes for 32 bits).
// Writes and finishes that produce no byte push no job into the queue.
// Synchronous active-low reset clears the residual, queue and output valid.
// A stalled output holds its byte; the queue absorbs the front end meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module msb_first_bit_packer #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [mbp_pkg::VALUE_W-1:0]   in_field_value,
  input  wire logic [mbp_pkg::LENGTH_W-1:0]  in_field_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mbp_pkg::BYTE_W-1:0]         out_byte,
  output logic                               out_last
);

  logic              push, q_full, head_valid, pop;
  mbp_pkg::mbp_job_t push_job, head_job;

  // Classify transactions and build byte jobs
  mbp_front #(
    .MaxFieldBits(MAX_FIELD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_field_value (in_field_value),
    .in_field_length(in_field_length),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  // Decouple front and back
  mbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop)
  );

  // Emit bytes, oldest first
  mbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire
